>>> hw/rtl/segment_tree_point_add_range_sum_macros.svh
`ifndef SEGMENT_TREE_POINT_ADD_RANGE_SUM_MACROS_SVH
`define SEGMENT_TREE_POINT_ADD_RANGE_SUM_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define SEGTREE_ASSERT_NOW(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Antecedent this cycle, consequent on the next edge.
`define SEGTREE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/segtree_pkg.sv
`timescale 1ns / 1ps

package segtree_pkg;

    localparam int LEAF_W = 11;
    localparam int POS_W  = 10;
    localparam int DATA_W = 32;

    typedef logic [LEAF_W-1:0]        leaf_t;
    typedef logic [POS_W-1:0]         pos_t;
    typedef logic [DATA_W-1:0]        word_t;
    typedef logic signed [DATA_W-1:0] sword_t;

    localparam leaf_t LEAF_RESET = 11'd1024;

    localparam logic MODE_ADD   = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

endpackage

>>> hw/rtl/segtree_if.sv
`timescale 1ns / 1ps

interface segtree_in_if;
    import segtree_pkg::*;

    logic   valid;
    logic   ready;
    logic   mode;
    pos_t   position;
    pos_t   right_end;
    sword_t delta;

    modport source (output valid, output mode, output position, output right_end,
                    output delta, input ready);
    modport sink   (input valid, input mode, input position, input right_end,
                    input delta, output ready);
endinterface

interface segtree_out_if;
    import segtree_pkg::*;

    logic   valid;
    logic   ready;
    sword_t range_sum;
    logic   bad_index;

    modport source (output valid, output range_sum, output bad_index, input ready);
    modport sink   (input valid, input range_sum, input bad_index, output ready);
endinterface

>>> hw/rtl/segment_tree_point_add_range_sum.sv
`timescale 1ns / 1ps

// Point-add / range-sum store kept as a bottom-up segment tree in one 2*MAX_LEAVES x 32
// memory (two registered read ports, one write port). After reset a clearing pass writes
// zero to every word with item.ready low; cfg writes are taken during it. One item is in
// work at a time, n being the active leaf count. An add reads the leaf, writes the leaf,
// then at each level reads the sibling while writing the parent, up to the root. A query
// reads both range ends together at each level, then loads the result register. An item
// with a bad position or an empty range goes straight to the result register. A result
// waits in the output register without holding off the next item; a new result waits for
// that register to free.
module segment_tree_point_add_range_sum #(
    parameter int MAX_LEAVES = 1024
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  segtree_pkg::leaf_t     cfg_wdata,
    segtree_in_if.sink             item,
    segtree_out_if.source          result
);
    import segtree_pkg::*;

    localparam int DEPTH = 2 * MAX_LEAVES;
    localparam int NW    = $clog2(DEPTH);
    localparam int CW    = ($clog2(MAX_LEAVES + 1) > LEAF_W) ? $clog2(MAX_LEAVES + 1) : LEAF_W;

    leaf_t         leaf_count_reg;
    logic [CW-1:0] leaf_ext;
    logic [CW-1:0] n_active;

    logic          mem_we;
    logic [NW-1:0] mem_waddr;
    word_t         mem_wdata;
    logic [NW-1:0] mem_raddr_a;
    logic [NW-1:0] mem_raddr_b;
    word_t         mem_rdata_a;
    word_t         mem_rdata_b;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            leaf_count_reg <= LEAF_RESET;
        end
        else if (cfg_we)
        begin
            leaf_count_reg <= cfg_wdata;
        end
    end

    // leaf_count above the tree size acts as the tree size
    assign leaf_ext = CW'(leaf_count_reg);
    assign n_active = (leaf_ext > CW'(MAX_LEAVES)) ? CW'(MAX_LEAVES) : leaf_ext;

    segtree_ctrl #(
        .MAX_LEAVES (MAX_LEAVES)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .n           (n_active),
        .item        (item),
        .result      (result),
        .mem_we      (mem_we),
        .mem_waddr   (mem_waddr),
        .mem_wdata   (mem_wdata),
        .mem_raddr_a (mem_raddr_a),
        .mem_raddr_b (mem_raddr_b),
        .mem_rdata_a (mem_rdata_a),
        .mem_rdata_b (mem_rdata_b)
    );

    segtree_mem #(
        .DEPTH (DEPTH),
        .AW    (NW)
    ) u_mem (
        .clk     (clk),
        .we      (mem_we),
        .waddr   (mem_waddr),
        .wdata   (mem_wdata),
        .raddr_a (mem_raddr_a),
        .raddr_b (mem_raddr_b),
        .rdata_a (mem_rdata_a),
        .rdata_b (mem_rdata_b)
    );

endmodule

>>> hw/rtl/segtree_mem.sv
`timescale 1ns / 1ps

module segtree_mem #(
    parameter int DEPTH = 2048,
    parameter int AW    = 11
) (
    input  logic                      clk,
    input  logic                      we,
    input  logic [AW-1:0]             waddr,
    input  segtree_pkg::word_t        wdata,
    input  logic [AW-1:0]             raddr_a,
    input  logic [AW-1:0]             raddr_b,
    output segtree_pkg::word_t        rdata_a,
    output segtree_pkg::word_t        rdata_b
);
    import segtree_pkg::*;

    word_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Two registered read ports; a read of the address being written returns old data.
    always_ff @(posedge clk)
    begin
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

>>> hw/rtl/segtree_ctrl.sv
`timescale 1ns / 1ps

module segtree_ctrl #(
    parameter int MAX_LEAVES = 1024,
    localparam int DEPTH = 2 * MAX_LEAVES,
    localparam int NW = $clog2(DEPTH),
    localparam int CW = ($clog2(MAX_LEAVES + 1) > segtree_pkg::LEAF_W) ?
                        $clog2(MAX_LEAVES + 1) : segtree_pkg::LEAF_W
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [CW-1:0]        n,
    segtree_in_if.sink           item,
    segtree_out_if.source        result,
    output logic                 mem_we,
    output logic [NW-1:0]        mem_waddr,
    output segtree_pkg::word_t   mem_wdata,
    output logic [NW-1:0]        mem_raddr_a,
    output logic [NW-1:0]        mem_raddr_b,
    input  segtree_pkg::word_t   mem_rdata_a,
    input  segtree_pkg::word_t   mem_rdata_b
);
    import segtree_pkg::*;

    localparam logic [2:0] ST_CLEAR    = 3'd0;
    localparam logic [2:0] ST_IDLE     = 3'd1;
    localparam logic [2:0] ST_ADD_RD   = 3'd2;
    localparam logic [2:0] ST_ADD_LEAF = 3'd3;
    localparam logic [2:0] ST_ADD_UP   = 3'd4;
    localparam logic [2:0] ST_Q_RD     = 3'd5;
    localparam logic [2:0] ST_Q_STEP   = 3'd6;
    localparam logic [2:0] ST_RESULT   = 3'd7;

    logic [2:0]    state_reg, state_next;
    logic [NW-1:0] node_reg, node_next;   // add: current node; query: left end
    logic [NW-1:0] r_reg, r_next;
    word_t         acc_reg, acc_next;     // add: running node value; query: sum
    word_t         delta_reg, delta_next;
    logic          bad_reg, bad_next;
    logic [NW-1:0] clr_cnt_reg, clr_cnt_next;

    logic          out_valid_reg;
    word_t         out_sum_reg;
    logic          out_bad_reg;
    logic          load_out;

    logic          accept;
    logic          out_free;
    logic          pos_bad;
    logic          rend_bad;
    logic [NW-1:0] leaf_l;
    logic [NW-1:0] leaf_r;
    logic [NW-1:0] parent;
    logic [NW:0]   l_inc;
    logic [NW-1:0] l_up;
    logic [NW-1:0] r_dec;
    logic [NW-1:0] r_up;
    word_t         add_a;
    word_t         add_b;
    word_t         q_sum;
    word_t         up_sum;
    word_t         leaf_sum;

    assign item.ready = (state_reg == ST_IDLE);
    assign accept     = item.valid && item.ready;
    assign out_free   = !out_valid_reg || result.ready;

    assign pos_bad  = CW'(item.position) >= n;
    assign rend_bad = CW'(item.right_end) >= n;
    assign leaf_l   = NW'(n) + NW'(item.position);
    assign leaf_r   = NW'(n) + NW'(item.right_end);

    assign parent   = {1'b0, node_reg[NW-1:1]};
    assign l_inc    = {1'b0, node_reg} + (NW+1)'(1);
    assign l_up     = l_inc[NW:1];
    assign r_dec    = r_reg - NW'(1);
    assign r_up     = {1'b0, r_dec[NW-1:1]};

    // Left end contributes when it is a right child, right end when a left child.
    assign add_a    = node_reg[0] ? mem_rdata_a : '0;
    assign add_b    = r_reg[0] ? '0 : mem_rdata_b;
    assign q_sum    = acc_reg + add_a + add_b;
    assign up_sum   = acc_reg + mem_rdata_a;
    assign leaf_sum = mem_rdata_a + delta_reg;

    always_comb
    begin
        state_next   = state_reg;
        node_next    = node_reg;
        r_next       = r_reg;
        acc_next     = acc_reg;
        delta_next   = delta_reg;
        bad_next     = bad_reg;
        clr_cnt_next = clr_cnt_reg;
        mem_we       = 1'b0;
        mem_waddr    = node_reg;
        mem_wdata    = acc_reg;
        mem_raddr_a  = node_reg;
        mem_raddr_b  = r_reg;
        load_out     = 1'b0;

        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_we       = 1'b1;
                mem_waddr    = clr_cnt_reg;
                mem_wdata    = '0;
                clr_cnt_next = clr_cnt_reg + NW'(1);
                if (clr_cnt_reg == NW'(DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                if (accept)
                begin
                    node_next  = leaf_l;
                    r_next     = leaf_r;
                    delta_next = item.delta;
                    acc_next   = '0;
                    bad_next   = 1'b0;
                    if (item.mode == MODE_ADD)
                    begin
                        if (pos_bad)
                        begin
                            bad_next   = 1'b1;
                            state_next = ST_RESULT;
                        end
                        else
                        begin
                            state_next = ST_ADD_RD;
                        end
                    end
                    else
                    begin
                        if (pos_bad || rend_bad)
                        begin
                            bad_next   = 1'b1;
                            state_next = ST_RESULT;
                        end
                        else if (item.position > item.right_end)
                        begin
                            state_next = ST_RESULT;
                        end
                        else
                        begin
                            state_next = ST_Q_RD;
                        end
                    end
                end
            end

            ST_ADD_RD:
            begin
                state_next = ST_ADD_LEAF;
            end

            ST_ADD_LEAF:
            begin
                mem_we      = 1'b1;
                mem_waddr   = node_reg;
                mem_wdata   = leaf_sum;
                acc_next    = leaf_sum;
                mem_raddr_a = node_reg ^ NW'(1);
                state_next  = (node_reg > NW'(1)) ? ST_ADD_UP : ST_IDLE;
            end

            ST_ADD_UP:
            begin
                // the sibling word is on port A; the parent gets the new pair sum
                mem_we      = 1'b1;
                mem_waddr   = parent;
                mem_wdata   = up_sum;
                acc_next    = up_sum;
                node_next   = parent;
                mem_raddr_a = parent ^ NW'(1);
                if (parent <= NW'(1))
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_Q_RD:
            begin
                state_next = ST_Q_STEP;
            end

            ST_Q_STEP:
            begin
                acc_next    = q_sum;
                node_next   = l_up;
                r_next      = r_up;
                mem_raddr_a = l_up;
                mem_raddr_b = r_up;
                if (l_up > r_up)
                begin
                    state_next = ST_RESULT;
                end
            end

            ST_RESULT:
            begin
                if (out_free)
                begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        node_reg  <= node_next;
        r_reg     <= r_next;
        acc_reg   <= acc_next;
        delta_reg <= delta_next;
        bad_reg   <= bad_next;
    end

    // Output register: a result may wait here while the next item is taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_sum_reg <= acc_reg;
            out_bad_reg <= bad_reg;
        end
    end

    assign result.valid     = out_valid_reg;
    assign result.range_sum = out_sum_reg;
    assign result.bad_index = out_bad_reg;

endmodule

>>> hw/rtl/segtree_checker.sv
`timescale 1ns / 1ps

`include "segment_tree_point_add_range_sum_macros.svh"

module segtree_checker (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 item_valid,
    input logic                 item_ready,
    input logic                 out_valid,
    input logic                 out_ready,
    input segtree_pkg::sword_t  range_sum,
    input logic                 bad_index
);
    import segtree_pkg::*;

    // a stalled result holds
    `SEGTREE_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(range_sum) && $stable(bad_index), "result changed while stalled")

    // a flagged item always reports a zero sum
    `SEGTREE_ASSERT_NOW(a_bad_zero, (out_valid && bad_index) |-> (range_sum == 32'sd0), "bad_index with nonzero sum")

    // one item at a time: after an input transfer the block is busy
    `SEGTREE_ASSERT_NEXT(a_busy_after_take, item_valid && item_ready, !item_ready, "ready right after an input transfer")

    // results are loaded only from the busy state
    `SEGTREE_ASSERT_NOW(a_result_when_busy, $rose(out_valid) |-> !$past(item_ready), "result appeared while idle")

endmodule

bind segment_tree_point_add_range_sum segtree_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item.valid),
    .item_ready (item.ready),
    .out_valid  (result.valid),
    .out_ready  (result.ready),
    .range_sum  (result.range_sum),
    .bad_index  (result.bad_index)
);

>>> tb/segment_tree_point_add_range_sum_test.sv
`timescale 1ns / 1ps

module segment_tree_point_add_range_sum_test;
    import segtree_pkg::*;

    localparam int unsigned TREE_LEAVES   = 1024;
    localparam int unsigned LIMIT_CYCLES  = 600000;
    localparam int unsigned SETTLE_CYCLES = 40;
    localparam int unsigned LONG_HOLD     = 400;
    localparam int unsigned NUM_PHASES    = 10;

    typedef struct {
        sword_t range_sum;
        logic   bad_index;
    } sum_result_t;

    // Tracks the tree contents and the sums still owed by the block.
    class range_sum_board;
        word_t       tree [2*TREE_LEAVES];
        leaf_t       leaf_count;
        sum_result_t sums_due [$];
        int unsigned errors;

        function new();
            foreach (tree[i]) tree[i] = '0;
            leaf_count = LEAF_RESET;
            errors     = 0;
        endfunction

        function void set_leaf_count(leaf_t v);
            leaf_count = v;
        endfunction

        function int unsigned active_leaves();
            return (leaf_count > TREE_LEAVES) ? TREE_LEAVES : int'(leaf_count);
        endfunction

        function void note_item(logic m, pos_t p, pos_t r, sword_t d);
            int unsigned n;
            int unsigned node;
            int unsigned lo;
            int unsigned hi;
            sum_result_t res;
            n             = active_leaves();
            res.range_sum = '0;
            res.bad_index = 1'b1;
            if (m == MODE_ADD) begin
                if (p < n) begin
                    node       = n + p;
                    tree[node] = tree[node] + d;
                    node       = node >> 1;
                    while (node != 0) begin
                        tree[node] = tree[2*node] + tree[2*node+1];
                        node       = node >> 1;
                    end
                    return;
                end
            end else if (p < n && r < n) begin
                // empty range falls out of the walk with a zero sum
                res.bad_index = 1'b0;
                lo = n + p;
                hi = n + r;
                while (lo <= hi) begin
                    if (lo[0])
                        res.range_sum = res.range_sum + tree[lo];
                    if (!hi[0])
                        res.range_sum = res.range_sum + tree[hi];
                    lo = (lo + 1) >> 1;
                    if (hi == 0)
                        break;
                    hi = (hi - 1) >> 1;
                end
            end
            sums_due.push_back(res);
        endfunction

        function void check_result(sword_t s, logic b);
            sum_result_t want;
            if (sums_due.size() == 0) begin
                $error("unexpected result: range_sum %0d bad_index %0b", s, b);
                errors++;
                return;
            end
            want = sums_due.pop_front();
            if (b !== want.bad_index) begin
                $error("bad_index: expected %0b, actual %0b", want.bad_index, b);
                errors++;
            end
            if (s !== want.range_sum) begin
                $error("range_sum: expected %0d, actual %0d", want.range_sum, s);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    leaf_t       cfg_wdata;
    int unsigned cycles = 0;
    logic        quiet = 1'b0;
    logic        hold_long = 1'b0;
    int unsigned send_gap_pct = 20;
    int unsigned recv_stall_pct = 20;

    range_sum_board board = new();

    segtree_in_if  item_ch ();
    segtree_out_if result_ch ();

    segment_tree_point_add_range_sum dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .item      (item_ch),
        .result    (result_ch)
    );

    initial clk = 1'b0;
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == LIMIT_CYCLES) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && result_ch.valid && result_ch.ready)
            board.check_result(result_ch.range_sum, result_ch.bad_index);
    end

    // result side: random stalls, plus one long hold-off on request
    initial
    begin
        bit long_done;
        long_done       = 1'b0;
        result_ch.ready = 1'b0;
        @(posedge rst_n);
        forever begin
            if (hold_long && !long_done) begin
                long_done = 1'b1;
                result_ch.ready <= 1'b0;
                for (int c = 0; c < LONG_HOLD; c++)
                    @(posedge clk);
            end else if (!quiet && $urandom_range(0, 99) < recv_stall_pct) begin
                result_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge clk);
            end else begin
                result_ch.ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    function automatic sword_t pick_delta();
        case ($urandom_range(0, 7))
            0: return sword_t'(32'h7FFF_FFFF);
            1: return sword_t'(32'h8000_0000);
            2: return sword_t'(32'hFFFF_FFFF);
            3: return sword_t'(32'($urandom_range(0, 200)) - 32'd100);
            default: return sword_t'($urandom);
        endcase
    endfunction

    // mostly in range; now and then anywhere in the 10-bit field
    function automatic pos_t pick_pos(int unsigned n);
        if (n == 0 || $urandom_range(0, 9) == 0)
            return pos_t'($urandom_range(0, 1023));
        return pos_t'($urandom_range(0, n - 1));
    endfunction

    task automatic send_item(input logic m, input pos_t p, input pos_t r, input sword_t d);
        if (!quiet && $urandom_range(0, 99) < send_gap_pct) begin
            item_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        item_ch.valid     <= 1'b1;
        item_ch.mode      <= m;
        item_ch.position  <= p;
        item_ch.right_end <= r;
        item_ch.delta     <= d;
        do @(posedge clk); while (!item_ch.ready);
        board.note_item(m, p, r, d);
    endtask

    task automatic send_random();
        int unsigned n;
        logic        m;
        pos_t        p;
        pos_t        r;
        n = board.active_leaves();
        m = logic'($urandom_range(0, 1));
        p = pick_pos(n);
        if (p < n && $urandom_range(0, 9) < 7)
            r = pos_t'($urandom_range(p, n - 1));
        else
            r = pick_pos(n);
        send_item(m, p, r, pick_delta());
    endtask

    task automatic wait_for_results();
        item_ch.valid <= 1'b0;
        do @(posedge clk); while (board.sums_due.size() != 0);
    endtask

    // adds leave no result behind, so allow the last walk to finish first
    task automatic write_leaf_count(input leaf_t v);
        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        board.set_leaf_count(v);
    endtask

    initial
    begin
        leaf_t       phase_leaves [NUM_PHASES];
        int unsigned phase_items [NUM_PHASES];
        int unsigned pct_choice [3];

        phase_leaves = '{11'd1024, 11'd1, 11'd2, 11'd37, 11'd0, 11'd2047, 11'd700,
                         11'd1023, leaf_t'($urandom_range(3, 1023)), 11'd1024};
        phase_items  = '{500, 40, 60, 150, 40, 200, 300, 250, 200, 190};
        pct_choice   = '{0, 15, 50};

        rst_n             = 1'b0;
        cfg_we            = 1'b0;
        cfg_wdata         = LEAF_RESET;
        item_ch.valid     = 1'b0;
        item_ch.mode      = MODE_ADD;
        item_ch.position  = '0;
        item_ch.right_end = '0;
        item_ch.delta     = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // full tree: extremes of delta and position, wrapping sums, empty ranges
        send_item(MODE_ADD,   10'd0,    10'd0,    sword_t'(32'h7FFF_FFFF));
        send_item(MODE_ADD,   10'd1023, 10'd1023, sword_t'(32'h8000_0000));
        send_item(MODE_ADD,   10'd1,    10'd0,    sword_t'(32'd1));
        send_item(MODE_ADD,   10'd512,  10'd1023, sword_t'(32'hFFFF_FFFF));
        send_item(MODE_ADD,   10'd300,  10'd5,    sword_t'(32'd0));
        send_item(MODE_QUERY, 10'd0,    10'd1023, sword_t'(32'd0));
        send_item(MODE_QUERY, 10'd0,    10'd0,    sword_t'(32'hFFFF_FFFF));
        send_item(MODE_QUERY, 10'd1023, 10'd1023, sword_t'(32'd0));
        send_item(MODE_QUERY, 10'd0,    10'd1,    sword_t'(32'd0));
        send_item(MODE_QUERY, 10'd5,    10'd3,    sword_t'(32'd0));
        send_item(MODE_QUERY, 10'd1023, 10'd0,    sword_t'(32'd0));
        send_item(MODE_QUERY, 10'd7,    10'd7,    sword_t'(32'd0));

        // single leaf: bad add, bad ends on either side
        write_leaf_count(11'd1);
        send_item(MODE_ADD,   10'd0, 10'd0, sword_t'(32'd5));
        send_item(MODE_ADD,   10'd1, 10'd0, sword_t'(32'd9));
        send_item(MODE_QUERY, 10'd0, 10'd0, sword_t'(32'd0));
        send_item(MODE_QUERY, 10'd0, 10'd1, sword_t'(32'd0));
        send_item(MODE_QUERY, 10'd1, 10'd0, sword_t'(32'd0));

        // no leaves: everything is out of range
        write_leaf_count(11'd0);
        send_item(MODE_ADD,   10'd0, 10'd0, sword_t'(32'd3));
        send_item(MODE_QUERY, 10'd0, 10'd0, sword_t'(32'd0));

        // oversized count behaves as the full tree
        write_leaf_count(11'd2047);
        send_item(MODE_ADD,   10'd1023, 10'd0,    sword_t'(32'd7));
        send_item(MODE_QUERY, 10'd0,    10'd1023, sword_t'(32'd0));

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            write_leaf_count(phase_leaves[ph]);
            quiet          = (ph == NUM_PHASES - 1);
            send_gap_pct   = pct_choice[$urandom_range(0, 2)];
            recv_stall_pct = pct_choice[$urandom_range(0, 2)];
            if (ph == 0)
                hold_long = 1'b1;
            for (int k = 0; k < phase_items[ph]; k++) begin
                if (k % 150 == 149)
                    wait_for_results();
                send_random();
            end
        end

        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (board.errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

>>> files.f
+incdir+hw/rtl
hw/rtl/segtree_pkg.sv
hw/rtl/segtree_if.sv
hw/rtl/segtree_mem.sv
hw/rtl/segtree_ctrl.sv
hw/rtl/segment_tree_point_add_range_sum.sv
hw/rtl/segtree_checker.sv
tb/segment_tree_point_add_range_sum_test.sv
